>>> src/scpe_pkg.sv
// ----------------------------------------------------------------------------
// scpe_pkg: shared types and constants of the stream channel protocol engine
// Command codes, channel and link state codes, and the front-to-back entry.
// ----------------------------------------------------------------------------
package scpe_pkg;

    localparam logic [31:0] CMD_CNXN     = 32'h4e584e43;
    localparam logic [31:0] CMD_OPEN     = 32'h4e45504f;
    localparam logic [31:0] CMD_OKAY     = 32'h59414b4f;
    localparam logic [31:0] CMD_CLSE     = 32'h45534c43;
    localparam logic [31:0] CMD_WRTE     = 32'h45545257;
    localparam logic [31:0] LINK_VERSION = 32'h01000000;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_HEADER = 3'd1;
    localparam logic [2:0] KIND_OPEN   = 3'd2;
    localparam logic [2:0] KIND_CLOSE  = 3'd3;
    localparam logic [2:0] KIND_WRITE  = 3'd4;
    localparam logic [2:0] KIND_RXERR  = 3'd5;

    localparam logic [2:0] EV_STATUS = 3'd0;
    localparam logic [2:0] EV_SEND   = 3'd1;
    localparam logic [2:0] EV_DATA   = 3'd2;
    localparam logic [2:0] EV_CLOSED = 3'd3;
    localparam logic [2:0] EV_OPEN   = 3'd4;

    localparam logic [2:0] SRC_NONE  = 3'd0;
    localparam logic [2:0] SRC_HOST  = 3'd1;
    localparam logic [2:0] SRC_NAME  = 3'd2;
    localparam logic [2:0] SRC_WRITE = 3'd3;
    localparam logic [2:0] SRC_RX    = 3'd4;

    localparam logic [1:0] LS_WAIT_ATTACH  = 2'd0;
    localparam logic [1:0] LS_WAIT_CONNECT = 2'd1;
    localparam logic [1:0] LS_CONNECTED    = 2'd2;
    localparam logic [1:0] LS_ERROR        = 2'd3;

    localparam logic [2:0] CS_FREE       = 3'd0;
    localparam logic [2:0] CS_START      = 3'd1;
    localparam logic [2:0] CS_WAIT_OPEN  = 3'd2;
    localparam logic [2:0] CS_IDLE       = 3'd3;
    localparam logic [2:0] CS_WAIT_READY = 3'd4;
    localparam logic [2:0] CS_CLOSE_REQ  = 3'd5;
    localparam logic [2:0] CS_WAIT_CLOSE = 3'd6;

    localparam logic [1:0] STAT_DOWN  = 2'd0;
    localparam logic [1:0] STAT_UP    = 2'd1;
    localparam logic [1:0] STAT_ERROR = 2'd2;

    localparam int MAX_RESULTS = 8;

    localparam logic [1:0] REG_MAX_RECEIVE = 2'd0;
    localparam logic [1:0] REG_HOST_NAME   = 2'd1;

    // One input word as it travels from the front to the back
    typedef struct packed {
        logic [2:0]  kind;
        logic        attached;
        logic [1:0]  sender_status;
        logic [31:0] command_word;
        logic [31:0] first_argument;
        logic [31:0] second_argument;
        logic [15:0] payload_len;
        logic [2:0]  channel;
    } item_t;

endpackage

>>> src/scpe_queue.sv
// ----------------------------------------------------------------------------
// scpe_queue: two-entry queue between front and back
// Decouples input acceptance from the channel table sequencer.
// ----------------------------------------------------------------------------
module scpe_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  scpe_pkg::item_t  push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output scpe_pkg::item_t  head
);

    scpe_pkg::item_t mem_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

>>> src/scpe_back.sv
// ----------------------------------------------------------------------------
// scpe_back: channel table and result sequencer
// Carries out one queued word at a time, scanning channels one per cycle.
// ----------------------------------------------------------------------------
module scpe_back #(
    parameter int CHANNELS = 8,
    parameter int NAME_MAX = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  scpe_pkg::item_t  item,
    output logic             item_pop,
    input  logic [15:0]      max_receive_bytes,
    input  logic [5:0]       host_name_length,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       event_res,
    output logic [31:0]      send_command,
    output logic [31:0]      send_first,
    output logic [31:0]      send_second,
    output logic [2:0]       payload_source,
    output logic [15:0]      result_length,
    output logic [3:0]       result_channel,
    output logic [1:0]       link_status,
    output logic             channel_ready,
    output logic             last
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW = $clog2(NAME_MAX);
    localparam int SW = $clog2(CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RESET,
        ST_OPEN,
        ST_EMIT,
        ST_FINISH
    } state_t;

    state_t          state_reg;
    scpe_pkg::item_t cur_reg;

    logic [1:0]      link_state_reg;
    logic [CW-1:0]   scan_pointer_reg;
    logic [23:0]     id_counter_reg;
    logic [2:0]      chan_state_reg   [CHANNELS];
    logic [31:0]     chan_local_reg   [CHANNELS];
    logic [31:0]     chan_remote_reg  [CHANNELS];
    logic            chan_ack_reg     [CHANNELS];
    logic            chan_data_reg    [CHANNELS];
    logic [15:0]     chan_len_reg     [CHANNELS];
    logic [NW-1:0]   chan_name_reg    [CHANNELS];

    logic [SW-1:0]   step_reg;
    logic [3:0]      nres_reg;
    logic            err_reg;
    logic            pend_reg;

    // pending result
    logic [2:0]      p_ev_reg;
    logic [31:0]     p_cmd_reg;
    logic [31:0]     p_a0_reg;
    logic [31:0]     p_a1_reg;
    logic [2:0]      p_src_reg;
    logic [15:0]     p_len_reg;
    logic [3:0]      p_ch_reg;

    // output register
    logic            ov_reg;
    logic [2:0]      o_ev_reg;
    logic [31:0]     o_cmd_reg;
    logic [31:0]     o_a0_reg;
    logic [31:0]     o_a1_reg;
    logic [2:0]      o_src_reg;
    logic [15:0]     o_len_reg;
    logic [3:0]      o_ch_reg;
    logic [1:0]      o_ls_reg;
    logic            o_rdy_reg;
    logic            o_last_reg;

    logic            out_free;
    logic [CW-1:0]   next_ptr;
    logic [CW-1:0]   step_idx;
    logic [CW-1:0]   hidx;
    logic            h_ok;
    logic [CW-1:0]   cidx;
    logic            c_ok;
    logic            ready_now;
    logic [1:0]      ls_now;

    assign out_free = !ov_reg || !out_stall;
    assign next_ptr = (32'(scan_pointer_reg) + 1 >= CHANNELS) ? '0 : scan_pointer_reg + 1'b1;
    assign step_idx = step_reg[CW-1:0];
    assign hidx     = cur_reg.second_argument[CW-1:0];
    assign h_ok     = (32'(cur_reg.second_argument[7:0]) < CHANNELS);
    assign cidx     = cur_reg.channel[CW-1:0];
    assign c_ok     = (32'(cur_reg.channel) < CHANNELS);
    assign ready_now = c_ok && chan_state_reg[cidx] == scpe_pkg::CS_IDLE
                       && !chan_data_reg[cidx];
    assign ls_now   = err_reg ? scpe_pkg::STAT_ERROR
                    : (link_state_reg == scpe_pkg::LS_CONNECTED) ? scpe_pkg::STAT_UP
                    : scpe_pkg::STAT_DOWN;

    assign item_pop       = (state_reg == ST_IDLE) && item_valid;
    assign out_valid      = ov_reg;
    assign event_res      = o_ev_reg;
    assign send_command   = o_cmd_reg;
    assign send_first     = o_a0_reg;
    assign send_second    = o_a1_reg;
    assign payload_source = o_src_reg;
    assign result_length  = o_len_reg;
    assign result_channel = o_ch_reg;
    assign link_status    = o_ls_reg;
    assign channel_ready  = o_rdy_reg;
    assign last           = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cur_reg          <= '0;
            link_state_reg   <= scpe_pkg::LS_WAIT_ATTACH;
            scan_pointer_reg <= '0;
            id_counter_reg   <= 24'd1;
            step_reg         <= '0;
            nres_reg         <= '0;
            err_reg          <= 1'b0;
            pend_reg         <= 1'b0;
            p_ev_reg         <= scpe_pkg::EV_STATUS;
            p_cmd_reg        <= '0;
            p_a0_reg         <= '0;
            p_a1_reg         <= '0;
            p_src_reg        <= scpe_pkg::SRC_NONE;
            p_len_reg        <= '0;
            p_ch_reg         <= '0;
            ov_reg           <= 1'b0;
            o_ev_reg         <= scpe_pkg::EV_STATUS;
            o_cmd_reg        <= '0;
            o_a0_reg         <= '0;
            o_a1_reg         <= '0;
            o_src_reg        <= scpe_pkg::SRC_NONE;
            o_len_reg        <= '0;
            o_ch_reg         <= '0;
            o_ls_reg         <= scpe_pkg::STAT_DOWN;
            o_rdy_reg        <= 1'b0;
            o_last_reg       <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                chan_state_reg[i]  <= scpe_pkg::CS_FREE;
                chan_local_reg[i]  <= '0;
                chan_remote_reg[i] <= '0;
                chan_ack_reg[i]    <= 1'b0;
                chan_data_reg[i]   <= 1'b0;
                chan_len_reg[i]    <= '0;
                chan_name_reg[i]   <= '0;
            end
        end
        else
        begin
            if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (item_valid)
                    begin
                        cur_reg   <= item;
                        state_reg <= ST_DECODE;
                        nres_reg  <= '0;
                        err_reg   <= 1'b0;
                        pend_reg  <= 1'b0;
                        step_reg  <= '0;
                        p_cmd_reg <= '0;
                        p_a0_reg  <= '0;
                        p_a1_reg  <= '0;
                        p_src_reg <= scpe_pkg::SRC_NONE;
                        p_len_reg <= '0;
                        p_ch_reg  <= 4'(item.channel);
                        p_ev_reg  <= scpe_pkg::EV_STATUS;
                    end
                end
                ST_DECODE:
                begin
                    state_reg <= ST_FINISH;
                    unique case (cur_reg.kind)
                        scpe_pkg::KIND_TICK:
                        begin
                            if (link_state_reg == scpe_pkg::LS_ERROR)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_RESET;
                            end
                            else if (link_state_reg == scpe_pkg::LS_WAIT_ATTACH)
                            begin
                                if (cur_reg.attached)
                                begin
                                    link_state_reg <= scpe_pkg::LS_WAIT_CONNECT;
                                    p_ev_reg  <= scpe_pkg::EV_SEND;
                                    p_cmd_reg <= scpe_pkg::CMD_CNXN;
                                    p_a0_reg  <= scpe_pkg::LINK_VERSION;
                                    p_a1_reg  <= {16'd0, max_receive_bytes};
                                    p_src_reg <= scpe_pkg::SRC_HOST;
                                    p_len_reg <= {10'd0, host_name_length};
                                    p_ch_reg  <= '0;
                                    pend_reg  <= 1'b1;
                                end
                            end
                            else if (!cur_reg.attached)
                            begin
                                state_reg <= ST_RESET;
                            end
                            else if (link_state_reg == scpe_pkg::LS_CONNECTED)
                            begin
                                if (cur_reg.sender_status[1])
                                begin
                                    link_state_reg <= scpe_pkg::LS_ERROR;
                                end
                                else if (!cur_reg.sender_status[0])
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                        end
                        scpe_pkg::KIND_HEADER:
                        begin
                            if (link_state_reg != scpe_pkg::LS_WAIT_ATTACH)
                            begin
                                if (cur_reg.command_word == scpe_pkg::CMD_CNXN)
                                begin
                                    link_state_reg <= scpe_pkg::LS_CONNECTED;
                                end
                                else if (h_ok && chan_local_reg[hidx] == cur_reg.second_argument)
                                begin
                                    if (cur_reg.command_word == scpe_pkg::CMD_OKAY)
                                    begin
                                        if (chan_state_reg[hidx] == scpe_pkg::CS_WAIT_OPEN)
                                        begin
                                            chan_remote_reg[hidx] <= cur_reg.first_argument;
                                            chan_state_reg[hidx]  <= scpe_pkg::CS_IDLE;
                                        end
                                        else if (chan_state_reg[hidx] == scpe_pkg::CS_WAIT_READY
                                                 && chan_remote_reg[hidx] == cur_reg.first_argument)
                                        begin
                                            chan_data_reg[hidx]  <= 1'b0;
                                            chan_state_reg[hidx] <= scpe_pkg::CS_IDLE;
                                        end
                                    end
                                    else if (cur_reg.command_word == scpe_pkg::CMD_CLSE)
                                    begin
                                        if (chan_state_reg[hidx] == scpe_pkg::CS_WAIT_OPEN
                                            || chan_state_reg[hidx] == scpe_pkg::CS_WAIT_READY
                                            || chan_state_reg[hidx] == scpe_pkg::CS_IDLE)
                                        begin
                                            p_ev_reg <= scpe_pkg::EV_CLOSED;
                                            p_ch_reg <= 4'(hidx);
                                            pend_reg <= 1'b1;
                                            chan_state_reg[hidx] <= scpe_pkg::CS_FREE;
                                        end
                                        else if (chan_state_reg[hidx] == scpe_pkg::CS_WAIT_CLOSE
                                                 || chan_state_reg[hidx] == scpe_pkg::CS_CLOSE_REQ)
                                        begin
                                            chan_state_reg[hidx] <= scpe_pkg::CS_FREE;
                                        end
                                    end
                                    else if (cur_reg.command_word == scpe_pkg::CMD_WRTE
                                             && chan_remote_reg[hidx] == cur_reg.first_argument)
                                    begin
                                        if (chan_state_reg[hidx] != scpe_pkg::CS_FREE
                                            && chan_state_reg[hidx] < scpe_pkg::CS_CLOSE_REQ
                                            && cur_reg.payload_len != '0)
                                        begin
                                            p_ev_reg  <= scpe_pkg::EV_DATA;
                                            p_src_reg <= scpe_pkg::SRC_RX;
                                            p_len_reg <= cur_reg.payload_len;
                                            p_ch_reg  <= 4'(hidx);
                                            pend_reg  <= 1'b1;
                                        end
                                        chan_ack_reg[hidx] <= 1'b1;
                                    end
                                end
                            end
                        end
                        scpe_pkg::KIND_OPEN:
                        begin
                            state_reg <= ST_OPEN;
                        end
                        scpe_pkg::KIND_CLOSE:
                        begin
                            if (c_ok && chan_state_reg[cidx] != scpe_pkg::CS_FREE)
                                chan_state_reg[cidx] <= scpe_pkg::CS_CLOSE_REQ;
                        end
                        scpe_pkg::KIND_WRITE:
                        begin
                            if (c_ok && chan_state_reg[cidx] == scpe_pkg::CS_IDLE)
                            begin
                                chan_data_reg[cidx] <= 1'b1;
                                chan_len_reg[cidx]  <= cur_reg.payload_len;
                            end
                        end
                        scpe_pkg::KIND_RXERR:
                        begin
                            if (link_state_reg != scpe_pkg::LS_WAIT_ATTACH)
                            begin
                                err_reg   <= 1'b1;
                                state_reg <= ST_RESET;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                // one channel per cycle, round-robin from the pointer
                ST_SCAN:
                begin
                    scan_pointer_reg <= next_ptr;
                    step_reg <= step_reg + 1'b1;
                    if (32'(step_reg) + 1 >= CHANNELS)
                        state_reg <= ST_FINISH;
                    if (chan_state_reg[next_ptr] == scpe_pkg::CS_START)
                    begin
                        chan_state_reg[next_ptr] <= scpe_pkg::CS_WAIT_OPEN;
                        p_ev_reg  <= scpe_pkg::EV_SEND;
                        p_cmd_reg <= scpe_pkg::CMD_OPEN;
                        p_a0_reg  <= chan_local_reg[next_ptr];
                        p_a1_reg  <= '0;
                        p_src_reg <= scpe_pkg::SRC_NAME;
                        p_len_reg <= 16'(chan_name_reg[next_ptr]) + 16'd1;
                        p_ch_reg  <= 4'(next_ptr);
                        pend_reg  <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (chan_state_reg[next_ptr] != scpe_pkg::CS_FREE
                             && chan_ack_reg[next_ptr])
                    begin
                        chan_ack_reg[next_ptr] <= 1'b0;
                        p_ev_reg  <= scpe_pkg::EV_SEND;
                        p_cmd_reg <= scpe_pkg::CMD_OKAY;
                        p_a0_reg  <= chan_local_reg[next_ptr];
                        p_a1_reg  <= chan_remote_reg[next_ptr];
                        p_ch_reg  <= 4'(next_ptr);
                        pend_reg  <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (chan_state_reg[next_ptr] == scpe_pkg::CS_CLOSE_REQ)
                    begin
                        chan_state_reg[next_ptr] <= scpe_pkg::CS_WAIT_CLOSE;
                        p_ev_reg  <= scpe_pkg::EV_SEND;
                        p_cmd_reg <= scpe_pkg::CMD_CLSE;
                        p_a0_reg  <= chan_local_reg[next_ptr];
                        p_a1_reg  <= chan_remote_reg[next_ptr];
                        p_ch_reg  <= 4'(next_ptr);
                        pend_reg  <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                    else if (chan_state_reg[next_ptr] == scpe_pkg::CS_IDLE
                             && chan_data_reg[next_ptr])
                    begin
                        chan_state_reg[next_ptr] <= scpe_pkg::CS_WAIT_READY;
                        p_ev_reg  <= scpe_pkg::EV_SEND;
                        p_cmd_reg <= scpe_pkg::CMD_WRTE;
                        p_a0_reg  <= chan_local_reg[next_ptr];
                        p_a1_reg  <= chan_remote_reg[next_ptr];
                        p_src_reg <= scpe_pkg::SRC_WRITE;
                        p_len_reg <= chan_len_reg[next_ptr];
                        p_ch_reg  <= 4'(next_ptr);
                        pend_reg  <= 1'b1;
                        state_reg <= ST_FINISH;
                    end
                end
                // first free channel, one per cycle
                ST_OPEN:
                begin
                    p_ev_reg <= scpe_pkg::EV_OPEN;
                    pend_reg <= 1'b1;
                    if (chan_state_reg[step_idx] == scpe_pkg::CS_FREE)
                    begin
                        chan_state_reg[step_idx] <= scpe_pkg::CS_START;
                        chan_name_reg[step_idx]  <= (cur_reg.payload_len >= 16'(NAME_MAX))
                                                    ? NW'(NAME_MAX - 1)
                                                    : cur_reg.payload_len[NW-1:0];
                        chan_ack_reg[step_idx]   <= 1'b0;
                        chan_data_reg[step_idx]  <= 1'b0;
                        chan_local_reg[step_idx] <= {id_counter_reg, 8'(step_idx)};
                        id_counter_reg <= id_counter_reg + 24'd1;
                        p_ch_reg  <= 4'(step_idx);
                        state_reg <= ST_FINISH;
                    end
                    else if (32'(step_reg) + 1 >= CHANNELS)
                    begin
                        p_ch_reg  <= 4'd8;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                // closed notice for each busy channel, up to MAX_RESULTS, and every channel cleared; the newest
                // notice is held back so that the final one can carry last
                ST_RESET:
                begin
                    if (out_free)
                    begin
                        if (chan_state_reg[step_idx] != scpe_pkg::CS_FREE
                            && 32'(nres_reg) < scpe_pkg::MAX_RESULTS)
                        begin
                            p_ev_reg <= scpe_pkg::EV_CLOSED;
                            p_ch_reg <= 4'(step_idx);
                            pend_reg <= 1'b1;
                            nres_reg <= nres_reg + 4'd1;
                            if (pend_reg)
                            begin
                                ov_reg     <= 1'b1;
                                o_ev_reg   <= scpe_pkg::EV_CLOSED;
                                o_cmd_reg  <= '0;
                                o_a0_reg   <= '0;
                                o_a1_reg   <= '0;
                                o_src_reg  <= scpe_pkg::SRC_NONE;
                                o_len_reg  <= '0;
                                o_ch_reg   <= p_ch_reg;
                                o_ls_reg   <= err_reg ? scpe_pkg::STAT_ERROR
                                                      : scpe_pkg::STAT_DOWN;
                                o_rdy_reg  <= 1'b0;
                                o_last_reg <= 1'b0;
                            end
                        end
                        chan_state_reg[step_idx]  <= scpe_pkg::CS_FREE;
                        chan_local_reg[step_idx]  <= '0;
                        chan_remote_reg[step_idx] <= '0;
                        chan_ack_reg[step_idx]    <= 1'b0;
                        chan_data_reg[step_idx]   <= 1'b0;
                        chan_len_reg[step_idx]    <= '0;
                        chan_name_reg[step_idx]   <= '0;
                        step_reg <= step_reg + 1'b1;
                        if (32'(step_reg) + 1 >= CHANNELS)
                        begin
                            link_state_reg <= scpe_pkg::LS_WAIT_ATTACH;
                            state_reg      <= ST_EMIT;
                        end
                    end
                end
                // hands over to the closing word: last notice gets its mark, or status result
                ST_EMIT:
                begin
                    state_reg <= ST_FINISH;
                end
                default: // ST_FINISH
                begin
                    if (out_free)
                    begin
                        state_reg  <= ST_IDLE;
                        ov_reg     <= 1'b1;
                        o_ls_reg   <= ls_now;
                        o_rdy_reg  <= ready_now;
                        o_last_reg <= 1'b1;
                        o_ev_reg   <= p_ev_reg;
                        o_ch_reg   <= p_ch_reg;
                        o_cmd_reg  <= p_cmd_reg;
                        o_a0_reg   <= p_a0_reg;
                        o_a1_reg   <= p_a1_reg;
                        o_src_reg  <= p_src_reg;
                        o_len_reg  <= p_len_reg;
                    end
                end
            endcase
        end
    end

endmodule

>>> src/stream_channel_protocol_engine_top.sv
// ----------------------------------------------------------------------------
// stream_channel_protocol_engine_top: host side of a multiplexed stream link
// Front accepts words into a short queue; back runs the channel table.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  input    | in        | in_valid/in_stall   | kind .. channel
//  output   | out       | out_valid/out_stall | event_res .. last
//  config   | in        | APB write/read      | max_receive_bytes, host_name_length
//
// One word at a time is carried out: the back takes it in idle, decodes it, then
// runs a channel scan (tick), a free-channel search (open) or a link reset where
// needed, and registers its final result in the finish state. The scan and the
// search visit one channel a cycle; the reset visits each channel in turn.
// The queue takes two words while the back works.
// Reset clears the link to wait-for-attach and frees every channel.
// An output stall holds the result register, and the sequencer in link reset and finish.
module stream_channel_protocol_engine_top #(
    parameter int CHANNELS = 8,
    parameter int NAME_MAX = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic        attached,
    input  logic [1:0]  sender_status,
    input  logic [31:0] command_word,
    input  logic [31:0] first_argument,
    input  logic [31:0] second_argument,
    input  logic [15:0] payload_len,
    input  logic [2:0]  channel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [31:0] send_command,
    output logic [31:0] send_first,
    output logic [31:0] send_second,
    output logic [2:0]  payload_source,
    output logic [15:0] result_length,
    output logic [3:0]  result_channel,
    output logic [1:0]  link_status,
    output logic        channel_ready,
    output logic        last
);

    logic [15:0]     max_rx_reg;
    logic [5:0]      host_len_reg;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    scpe_pkg::item_t q_head;
    scpe_pkg::item_t in_item;

    assign pready   = 1'b1;
    assign in_stall = q_full;

    always_comb
    begin
        in_item.kind            = kind;
        in_item.attached        = attached;
        in_item.sender_status   = sender_status;
        in_item.command_word    = command_word;
        in_item.first_argument  = first_argument;
        in_item.second_argument = second_argument;
        in_item.payload_len     = payload_len;
        in_item.channel         = channel;
    end

    // register file: index is the word address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_rx_reg   <= 16'd4096;
            host_len_reg <= 6'd7;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == 1'b0 && paddr[1:0] == 2'd0)
                max_rx_reg <= pwdata[15:0];
            else if (paddr[2] == 1'b1 && paddr[1:0] == 2'd0)
                host_len_reg <= pwdata[5:0];
        end
    end

    always_comb
    begin
        unique case ({1'b0, paddr[2]})
            scpe_pkg::REG_MAX_RECEIVE: prdata = {16'd0, max_rx_reg};
            scpe_pkg::REG_HOST_NAME:   prdata = {26'd0, host_len_reg};
            default:                   prdata = '0;
        endcase
    end

    scpe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && !q_full),
        .push_item (in_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    scpe_back #(
        .CHANNELS (CHANNELS),
        .NAME_MAX (NAME_MAX)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (q_valid),
        .item              (q_head),
        .item_pop          (q_pop),
        .max_receive_bytes (max_rx_reg),
        .host_name_length  (host_len_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .event_res         (event_res),
        .send_command      (send_command),
        .send_first        (send_first),
        .send_second       (send_second),
        .payload_source    (payload_source),
        .result_length     (result_length),
        .result_channel    (result_channel),
        .link_status       (link_status),
        .channel_ready     (channel_ready),
        .last              (last)
    );

endmodule
